// ----- rtl/core/annexb_slice_peek_resync_gate_top_defines.svh -----
// Assertion macros shared by the checker of the slice peek and resync gate.
`ifndef ANNEXB_SLICE_PEEK_RESYNC_GATE_TOP_DEFINES_SVH
`define ANNEXB_SLICE_PEEK_RESYNC_GATE_TOP_DEFINES_SVH

// Checked on every rising edge of clk while rst_n is high.
`define ASRG_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASRG_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/asrg_pkg.sv -----
// Types and constants of the slice peek and resync gate.
package asrg_pkg;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_OUTCOME = 2'd1,
        MODE_RESYNC  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        VERDICT_DECODE     = 3'd0,
        VERDICT_SKIP       = 3'd1,
        VERDICT_REJECT     = 3'd2,
        VERDICT_DECODED_OK = 3'd3,
        VERDICT_TIMEOUT    = 3'd4,
        VERDICT_FAILED     = 3'd5
    } verdict_t;

    localparam logic [1:0] OUTCOME_OK      = 2'd0;
    localparam logic [1:0] OUTCOME_TIMEOUT = 2'd1;

    localparam logic [15:0] SCAN_LIMIT_RESET = 16'd2048;
    localparam logic [15:0] POS_MAX          = 16'hFFFF;
    localparam logic [1:0]  ZERO_RUN_SAT     = 2'd2;
    localparam logic [4:0]  NAL_TYPE_MIN     = 5'd1;
    localparam logic [4:0]  NAL_TYPE_IDR     = 5'd5;
    localparam logic [7:0]  START_CODE_END   = 8'h01;

    // Register decode on paddr[2]: register 0 is scan_limit.
    localparam logic REG_SCAN_LIMIT = 1'b0;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] data_byte;
        logic       last;
        logic [1:0] outcome;
    } item_t;

    typedef struct packed {
        verdict_t verdict;
        logic     status_error;
        logic     recycle;
        logic     found_idr;
        logic     found_ref;
    } result_t;

endpackage

// ----- rtl/core/asrg_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface asrg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last;
    logic [1:0] outcome;

    modport source (output valid, output mode, output data_byte, output last,
                    output outcome, input ready);
    modport sink   (input valid, input mode, input data_byte, input last,
                    input outcome, output ready);
endinterface

interface asrg_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic       status_error;
    logic       recycle;
    logic       found_idr;
    logic       found_ref;

    modport source (output valid, output verdict, output status_error,
                    output recycle, output found_idr, output found_ref, input ready);
    modport sink   (input valid, input verdict, input status_error,
                    input recycle, input found_idr, input found_ref, output ready);
endinterface

// ----- rtl/core/asrg_gate.sv -----
// Start code scanner, per-unit slice flags and the resync gate decision.
module asrg_gate
    import asrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  item_t       item,
    input  logic [15:0] scan_limit,
    output result_t     res,
    output logic        res_valid
);

    logic        skip_pending_reg, skip_pending_next;
    logic [1:0]  zero_run_reg, zero_run_next;
    logic        expect_header_reg, expect_header_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic        slice_found_reg, slice_found_next;
    logic        unit_idr_reg, unit_idr_next;
    logic        unit_ref_reg, unit_ref_next;
    logic [4:0]  nal_type;

    assign nal_type = item.data_byte[4:0];

    always_comb
    begin
        skip_pending_next  = skip_pending_reg;
        zero_run_next      = zero_run_reg;
        expect_header_next = expect_header_reg;
        byte_position_next = byte_position_reg;
        slice_found_next   = slice_found_reg;
        unit_idr_next      = unit_idr_reg;
        unit_ref_next      = unit_ref_reg;
        res                = '0;
        res_valid          = 1'b0;

        case (item.mode)
            MODE_BYTE:
            begin
                if (!slice_found_reg && (byte_position_reg < scan_limit))
                begin
                    if (expect_header_reg && (nal_type inside {[NAL_TYPE_MIN:NAL_TYPE_IDR]}))
                    begin
                        slice_found_next   = 1'b1;
                        expect_header_next = 1'b0;
                        unit_idr_next      = (nal_type == NAL_TYPE_IDR);
                        unit_ref_next      = (item.data_byte[6:5] != 2'd0);
                    end
                    else
                    begin
                        // A non-slice header byte still feeds the next zero run.
                        expect_header_next = (zero_run_reg == ZERO_RUN_SAT) &&
                                             (item.data_byte == START_CODE_END);
                        if (item.data_byte == 8'd0)
                        begin
                            zero_run_next = (zero_run_reg == ZERO_RUN_SAT) ?
                                            ZERO_RUN_SAT : zero_run_reg + 2'd1;
                        end
                        else
                        begin
                            zero_run_next = 2'd0;
                        end
                    end
                end
                if (byte_position_reg != POS_MAX)
                begin
                    byte_position_next = byte_position_reg + 16'd1;
                end
                if (item.last)
                begin
                    res_valid = 1'b1;
                    if (!slice_found_next)
                    begin
                        unit_idr_next     = 1'b0;
                        unit_ref_next     = 1'b0;
                        skip_pending_next = 1'b1;
                        res.verdict       = VERDICT_REJECT;
                        res.status_error  = 1'b1;
                        res.recycle       = 1'b1;
                    end
                    else if (skip_pending_reg && !unit_idr_next)
                    begin
                        res.verdict = VERDICT_SKIP;
                    end
                    else
                    begin
                        skip_pending_next = 1'b0;
                        res.verdict       = VERDICT_DECODE;
                    end
                    res.found_idr      = unit_idr_next;
                    res.found_ref      = unit_ref_next;
                    zero_run_next      = 2'd0;
                    expect_header_next = 1'b0;
                    byte_position_next = '0;
                    slice_found_next   = 1'b0;
                end
            end
            MODE_OUTCOME:
            begin
                res_valid     = 1'b1;
                res.found_idr = unit_idr_reg;
                res.found_ref = unit_ref_reg;
                if (item.outcome == OUTCOME_OK)
                begin
                    res.verdict = VERDICT_DECODED_OK;
                end
                else if (item.outcome == OUTCOME_TIMEOUT)
                begin
                    res.verdict = VERDICT_TIMEOUT;
                    if (unit_ref_reg || unit_idr_reg)
                    begin
                        res.recycle       = 1'b1;
                        skip_pending_next = 1'b1;
                    end
                end
                else
                begin
                    res.verdict      = VERDICT_FAILED;
                    res.status_error = 1'b1;
                end
            end
            MODE_RESYNC:
            begin
                skip_pending_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_pending_reg  <= 1'b0;
            zero_run_reg      <= 2'd0;
            expect_header_reg <= 1'b0;
            byte_position_reg <= '0;
            slice_found_reg   <= 1'b0;
            unit_idr_reg      <= 1'b0;
            unit_ref_reg      <= 1'b0;
        end
        else if (fire)
        begin
            skip_pending_reg  <= skip_pending_next;
            zero_run_reg      <= zero_run_next;
            expect_header_reg <= expect_header_next;
            byte_position_reg <= byte_position_next;
            slice_found_reg   <= slice_found_next;
            unit_idr_reg      <= unit_idr_next;
            unit_ref_reg      <= unit_ref_next;
        end
    end

endmodule

// ----- rtl/core/annexb_slice_peek_resync_gate_top.sv -----
// A result passes the input register and then the output register before it leaves.
// Throughput: one item per cycle unless an item with a result waits on a full output register.
// Items that give no result still pass the input register.
// Reset (rst_n low, asynchronous) empties both registers, clears all scan and
// resync state, and sets scan_limit to 2048.
module annexb_slice_peek_resync_gate_top
    import asrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    asrg_in_if.sink     item_in,
    asrg_out_if.source  result_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        s1_valid_reg;
    item_t       s1_item_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg;
    logic [15:0] scan_limit_reg;
    result_t     gate_res;
    logic        gate_res_valid;
    logic        out_free;
    logic        advance;
    logic        in_fire;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SCAN_LIMIT) ? {16'd0, scan_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_limit_reg <= SCAN_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_SCAN_LIMIT))
        begin
            scan_limit_reg <= pwdata[15:0];
        end
    end

    // An item with no result never waits on the output register.
    assign out_free = !out_valid_reg || result_out.ready;
    assign advance  = s1_valid_reg && (!gate_res_valid || out_free);
    assign item_in.ready = !s1_valid_reg || advance;
    assign in_fire  = item_in.valid && item_in.ready;

    asrg_gate u_gate (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (s1_item_reg),
        .scan_limit (scan_limit_reg),
        .res        (gate_res),
        .res_valid  (gate_res_valid)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && gate_res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_in.ready)
            begin
                s1_valid_reg <= item_in.valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.mode      <= mode_t'(item_in.mode);
            s1_item_reg.data_byte <= item_in.data_byte;
            s1_item_reg.last      <= item_in.last;
            s1_item_reg.outcome   <= item_in.outcome;
        end
        if (advance && gate_res_valid)
        begin
            out_data_reg <= gate_res;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.verdict      = out_data_reg.verdict;
    assign result_out.status_error = out_data_reg.status_error;
    assign result_out.recycle      = out_data_reg.recycle;
    assign result_out.found_idr    = out_data_reg.found_idr;
    assign result_out.found_ref    = out_data_reg.found_ref;

endmodule

// ----- rtl/core/asrg_checker.sv -----
// Port-level checks of the slice peek and resync gate, bound to its top level.
`include "annexb_slice_peek_resync_gate_top_defines.svh"

module asrg_checker
    import asrg_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] verdict,
    input logic       status_error,
    input logic       recycle,
    input logic       found_idr,
    input logic       found_ref,
    input logic       pready
);

    `ASRG_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(verdict), "result transaction dropped or changed while stalled")

    `ASRG_CHECK(a_error_code, out_valid |-> (status_error == ((verdict == VERDICT_REJECT) || (verdict == VERDICT_FAILED))), "status_error does not match the verdict")

    `ASRG_CHECK(a_recycle_code, out_valid && recycle |-> (verdict == VERDICT_REJECT) || (verdict == VERDICT_TIMEOUT), "recycle raised on a verdict that never reclaims pictures")

    `ASRG_CHECK(a_reject_flags, out_valid && (verdict == VERDICT_REJECT) |-> recycle && !found_idr && !found_ref, "rejected unit reports slice flags")

    `ASRG_CHECK_ALWAYS(a_pready, pready, "configuration port stalled")

endmodule

bind annexb_slice_peek_resync_gate_top asrg_checker u_asrg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .verdict      (result_out.verdict),
    .status_error (result_out.status_error),
    .recycle      (result_out.recycle),
    .found_idr    (result_out.found_idr),
    .found_ref    (result_out.found_ref),
    .pready       (pready)
);

// ----- verif/testbench.sv -----
// Self-checking testbench of the Annex B slice peek and resync gate: directed, window and random units.
`timescale 1ns / 100ps

module testbench;
    import asrg_pkg::*;

    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam logic [1:0] OUTCOME_FAILURE = 2'd2;
    localparam logic [1:0] OUTCOME_UNUSED  = 2'd3;
    localparam logic [2:0] ADDR_SCAN_LIMIT = 3'd0;
    localparam int         STALL_LIMIT     = 4000;
    localparam int         SETTLE_CYCLES   = 6;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    asrg_in_if  item_ch ();
    asrg_out_if result_ch ();

    annexb_slice_peek_resync_gate_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 clk = ~clk;

    // Predicted gate state, kept in step with every accepted item.
    logic [15:0] window_limit = SCAN_LIMIT_RESET;
    logic        skip_armed   = 1'b0;
    logic [1:0]  zeros_seen   = 2'd0;
    logic        header_next  = 1'b0;
    logic [15:0] unit_pos     = 16'd0;
    logic        slice_locked = 1'b0;
    logic        unit_is_idr  = 1'b0;
    logic        unit_has_ref = 1'b0;

    result_t expected_verdicts[$];
    int      mismatches    = 0;
    int      items_sent    = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      quiet_cycles  = 0;

    // Works out the verdict, if any, that one accepted item gives.
    task automatic gate_step(logic [1:0] mode, logic [7:0] b, logic is_last, logic [1:0] oc);
        result_t    verdict_item;
        logic       has_verdict;
        logic       took_slice;
        logic [4:0] nal_kind;
        has_verdict = 1'b0;
        took_slice = 1'b0;
        verdict_item = '0;
        nal_kind = b[4:0];
        if (mode == MODE_BYTE) begin
            if (!slice_locked && unit_pos < window_limit) begin
                if (header_next) begin
                    header_next = 1'b0;
                    if (nal_kind >= NAL_TYPE_MIN && nal_kind <= NAL_TYPE_IDR) begin
                        slice_locked = 1'b1;
                        unit_is_idr = (nal_kind == NAL_TYPE_IDR);
                        unit_has_ref = (b[6:5] != 2'd0);
                        took_slice = 1'b1;
                    end
                end
                if (!took_slice) begin
                    // A header byte that is not a slice still feeds the zero run.
                    if (zeros_seen >= ZERO_RUN_SAT && b == START_CODE_END)
                        header_next = 1'b1;
                    if (b == 8'h00)
                        zeros_seen = (zeros_seen >= ZERO_RUN_SAT) ? ZERO_RUN_SAT
                                                                  : zeros_seen + 2'd1;
                    else
                        zeros_seen = 2'd0;
                end
            end
            if (unit_pos < POS_MAX)
                unit_pos = unit_pos + 16'd1;
            if (is_last) begin
                zeros_seen = 2'd0;
                header_next = 1'b0;
                unit_pos = 16'd0;
                has_verdict = 1'b1;
                if (!slice_locked) begin
                    unit_is_idr = 1'b0;
                    unit_has_ref = 1'b0;
                    skip_armed = 1'b1;
                    verdict_item.verdict = VERDICT_REJECT;
                    verdict_item.status_error = 1'b1;
                    verdict_item.recycle = 1'b1;
                end
                else begin
                    slice_locked = 1'b0;
                    if (skip_armed && !unit_is_idr) begin
                        verdict_item.verdict = VERDICT_SKIP;
                    end
                    else begin
                        skip_armed = 1'b0;
                        verdict_item.verdict = VERDICT_DECODE;
                    end
                end
            end
        end
        else if (mode == MODE_OUTCOME) begin
            has_verdict = 1'b1;
            if (oc == OUTCOME_OK) begin
                verdict_item.verdict = VERDICT_DECODED_OK;
            end
            else if (oc == OUTCOME_TIMEOUT) begin
                verdict_item.verdict = VERDICT_TIMEOUT;
                if (unit_has_ref || unit_is_idr) begin
                    skip_armed = 1'b1;
                    verdict_item.recycle = 1'b1;
                end
            end
            else begin
                verdict_item.verdict = VERDICT_FAILED;
                verdict_item.status_error = 1'b1;
            end
        end
        else if (mode == MODE_RESYNC) begin
            skip_armed = 1'b0;
        end
        if (has_verdict) begin
            verdict_item.found_idr = unit_is_idr;
            verdict_item.found_ref = unit_has_ref;
            expected_verdicts.push_back(verdict_item);
        end
    endtask

    task automatic send_item(logic [1:0] mode, logic [7:0] b, logic is_last, logic [1:0] oc);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= mode;
        item_ch.data_byte <= b;
        item_ch.last      <= is_last;
        item_ch.outcome   <= oc;
        do begin
            @(posedge clk);
        end while (!item_ch.ready);
        gate_step(mode, b, is_last, oc);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic send_bytes(logic [7:0] unit_bytes[$]);
        foreach (unit_bytes[i])
            send_item(MODE_BYTE, unit_bytes[i], i == unit_bytes.size() - 1,
                      2'($urandom_range(3)));
    endtask

    // Lowers valid and waits until every verdict has come and the pipeline is empty.
    task automatic drain_verdicts();
        item_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic is_write, logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_SCAN_LIMIT;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_scan_limit(logic [15:0] limit_value);
        logic [31:0] readback;
        drain_verdicts();
        apb_access(1'b1, {16'd0, limit_value}, readback);
        window_limit = limit_value;
        apb_access(1'b0, 32'd0, readback);
        if (readback[15:0] !== window_limit) begin
            $display("%0t: scan_limit readback expected %0d actual %0d",
                     $time, window_limit, readback[15:0]);
            mismatches++;
        end
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return START_CODE_END;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] header_byte();
        logic [4:0] nal_kind;
        nal_kind = ($urandom_range(9) < 6) ? 5'($urandom_range(1, 5)) : 5'($urandom_range(31));
        return {($urandom_range(7) == 0), 2'($urandom_range(3)), nal_kind};
    endfunction

    task automatic send_side_item();
        logic [1:0] mode;
        case ($urandom_range(9))
            7, 8: mode = MODE_RESYNC;
            9: mode = MODE_UNUSED;
            default: mode = MODE_OUTCOME;
        endcase
        send_item(mode, 8'($urandom_range(255)), 1'($urandom_range(1)), 2'($urandom_range(3)));
    endtask

    // Builds a unit of filler and start codes, sometimes cut short, with side items mixed in.
    task automatic send_random_unit();
        logic [7:0] unit_bytes[$];
        int         keep;
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(14) == 0)
                repeat ($urandom_range(20, 80)) unit_bytes.push_back(noise_byte());
            else
                repeat ($urandom_range(0, 5)) unit_bytes.push_back(noise_byte());
            if ($urandom_range(1))
                unit_bytes.push_back(8'h00);
            unit_bytes.push_back(8'h00);
            unit_bytes.push_back(8'h00);
            unit_bytes.push_back(START_CODE_END);
            unit_bytes.push_back(header_byte());
        end
        repeat ($urandom_range(0, 8)) unit_bytes.push_back(noise_byte());
        if (unit_bytes.size() > 1 && $urandom_range(9) == 0) begin
            keep = $urandom_range(1, unit_bytes.size());
            while (unit_bytes.size() > keep)
                void'(unit_bytes.pop_back());
        end
        if (unit_bytes.size() == 0)
            unit_bytes.push_back(noise_byte());
        foreach (unit_bytes[i]) begin
            if ($urandom_range(99) < 3)
                send_side_item();
            send_item(MODE_BYTE, unit_bytes[i], i == unit_bytes.size() - 1,
                      2'($urandom_range(3)));
        end
    endtask

    task automatic test_directed_items();
        send_item(MODE_OUTCOME, 8'h00, 1'b0, OUTCOME_OK);
        // IDR slice with the forbidden bit set, header on the final byte.
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'hE5});
        send_item(MODE_OUTCOME, 8'hFF, 1'b1, OUTCOME_TIMEOUT);
        // A non-slice header of zero starts the next start code's zero run.
        send_bytes('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h21});
        send_item(MODE_RESYNC, 8'h00, 1'b0, OUTCOME_OK);
        send_item(MODE_UNUSED, 8'hFF, 1'b1, OUTCOME_UNUSED);
        // Start code on the last byte leaves its header past the end of the unit.
        send_bytes('{8'h00, 8'h00, 8'h01});
        send_item(MODE_OUTCOME, 8'h00, 1'b0, OUTCOME_FAILURE);
        send_item(MODE_OUTCOME, 8'h00, 1'b0, OUTCOME_UNUSED);
    endtask

    task automatic test_scan_window();
        set_scan_limit(16'd4);
        send_bytes('{8'h00, 8'h00, 8'h01, 8'h41});
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'h65});
        // Below four no header can lie inside the window.
        set_scan_limit(16'd3);
        send_bytes('{8'h00, 8'h00, 8'h01, 8'h65});
    endtask

    task automatic test_random_traffic(int item_count);
        int target;
        target = items_sent + item_count;
        while (items_sent < target) begin
            send_random_unit();
            if ($urandom_range(99) < 60)
                send_side_item();
        end
    endtask

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk) begin
        result_t seen;
        result_t wanted;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            seen.verdict      = verdict_t'(result_ch.verdict);
            seen.status_error = result_ch.status_error;
            seen.recycle      = result_ch.recycle;
            seen.found_idr    = result_ch.found_idr;
            seen.found_ref    = result_ch.found_ref;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result verdict %0d err %0b rec %0b idr %0b ref %0b",
                         $time, seen.verdict, seen.status_error, seen.recycle,
                         seen.found_idr, seen.found_ref);
                mismatches++;
            end
            else begin
                wanted = expected_verdicts.pop_front();
                if (seen.verdict !== wanted.verdict || seen.status_error !== wanted.status_error
                    || seen.recycle !== wanted.recycle || seen.found_idr !== wanted.found_idr
                    || seen.found_ref !== wanted.found_ref) begin
                    $display("%0t: expected verdict %0d err %0b rec %0b idr %0b ref %0b, %s",
                             $time, wanted.verdict, wanted.status_error, wanted.recycle,
                             wanted.found_idr, wanted.found_ref, "actual below");
                    $display("%0t: actual   verdict %0d err %0b rec %0b idr %0b ref %0b",
                             $time, seen.verdict, seen.status_error, seen.recycle,
                             seen.found_idr, seen.found_ref);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run when no transaction moves on any port for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.mode      = MODE_BYTE;
        item_ch.data_byte = 8'h00;
        item_ch.last      = 1'b0;
        item_ch.outcome   = OUTCOME_OK;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = ADDR_SCAN_LIMIT;
        pwdata            = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 28;
        recv_idle_pct = 86;
        set_scan_limit(SCAN_LIMIT_RESET);
        test_directed_items();
        test_scan_window();
        set_scan_limit(16'($urandom_range(4, 24)));
        test_random_traffic(450);

        send_idle_pct = 86;
        recv_idle_pct = 28;
        set_scan_limit(16'd4);
        test_random_traffic(200);
        set_scan_limit(16'hFFFF);
        test_random_traffic(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_scan_limit(16'($urandom_range(5, 40)));
        test_random_traffic(450);

        drain_verdicts();
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- annexb_slice_peek_resync_gate_top.f -----
+incdir+rtl/core
rtl/core/asrg_pkg.sv
rtl/core/asrg_if.sv
rtl/core/asrg_gate.sv
rtl/core/annexb_slice_peek_resync_gate_top.sv
rtl/core/asrg_checker.sv
verif/testbench.sv
